@@ src/hms_pkg.sv @@
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types and constants for the Hall motion supervisor.
// ----------------------------------------------------------------------------
package hms_pkg;

  // Door motion state as carried on each beat; code 3 counts as idle.
  typedef enum logic [1:0] {
    DOOR_IDLE    = 2'd0,
    DOOR_OPENING = 2'd1,
    DOOR_CLOSING = 2'd2
  } door_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SAMPLE_PERIOD   = 3'd0,
    CFG_STALL_LIMIT     = 3'd1,
    CFG_DIRECTION_LIMIT = 3'd2,
    CFG_OPEN_LIMIT      = 3'd3,
    CFG_SETTLE_TICKS    = 3'd4
  } cfg_reg_t;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned PERIOD_BITS    = 8;
  localparam int unsigned LIMIT_BITS     = 16;
  localparam int unsigned SETTLE_BITS    = 8;
  localparam int unsigned TIMER_BITS     = 16;

  localparam logic [PERIOD_BITS-1:0] SAMPLE_PERIOD_RESET   = 8'd5;
  localparam logic [LIMIT_BITS-1:0]  STALL_LIMIT_RESET     = 16'd50;
  localparam logic [LIMIT_BITS-1:0]  DIRECTION_LIMIT_RESET = 16'd50;
  localparam logic [LIMIT_BITS-1:0]  OPEN_LIMIT_RESET      = 16'hFFFF;
  localparam logic [SETTLE_BITS-1:0] SETTLE_TICKS_RESET    = 8'd60;

  localparam logic [TIMER_BITS-1:0]  ERROR_TIMER_MAX       = 16'hFFFF;

endpackage

@@ src/hall_motion_supervisor.sv @@
// ----------------------------------------------------------------------------
// hall_motion_supervisor
// Door motion supervision from Hall position counts: periodic speed and
// direction sampling, settle gating, stall detection and Hall fault checks.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Beat contents
//  --------+-----------+-----------------------+-------------------------------
//  in      | in        | in_valid / in_stall   | hall_count, door_state,
//          |           |                       | flags_clear
//  out     | out       | out_valid / out_stall | speed, direction, stall_flag,
//          |           |                       | hall_fault, checks_active
//  cfg     | in        | cfg_write (no wait)   | cfg_index, cfg_data
//
// One beat in, one beat out. A beat lands in the input register, then one
// pass of compare and subtract logic updates the supervision state and the
// result register on the next edge; one beat per cycle while out_stall is low.
// The input register refills whenever the result register is empty or drained
// in the same cycle, so out_stall backs up into in_stall in the same cycle.
// rst (synchronous, active high) clears the supervision state, the pipeline
// valids and reloads the configuration registers with their reset values.
//
module hall_motion_supervisor #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [COUNT_BITS-1:0]                hall_count,
  input  logic [1:0]                           door_state,
  input  logic                                 flags_clear,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [COUNT_BITS-1:0]                speed,
  output logic                                 direction,
  output logic                                 stall_flag,
  output logic                                 hall_fault,
  output logic                                 checks_active,
  // configuration port
  input  logic                                 cfg_write,
  input  logic [hms_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [hms_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  // Width that holds both the open limit and a count, so the limit can be
  // widened or narrowed to the count width.
  localparam int unsigned OPEN_EXT_BITS =
    (COUNT_BITS > hms_pkg::LIMIT_BITS) ? COUNT_BITS : hms_pkg::LIMIT_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [hms_pkg::PERIOD_BITS-1:0] sample_period;
  logic [hms_pkg::LIMIT_BITS-1:0]  stall_limit;
  logic [hms_pkg::LIMIT_BITS-1:0]  direction_limit;
  logic [hms_pkg::LIMIT_BITS-1:0]  open_limit;
  logic [hms_pkg::SETTLE_BITS-1:0] settle_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period   <= hms_pkg::SAMPLE_PERIOD_RESET;
      stall_limit     <= hms_pkg::STALL_LIMIT_RESET;
      direction_limit <= hms_pkg::DIRECTION_LIMIT_RESET;
      open_limit      <= hms_pkg::OPEN_LIMIT_RESET;
      settle_ticks    <= hms_pkg::SETTLE_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        hms_pkg::CFG_SAMPLE_PERIOD:   sample_period   <= cfg_data[hms_pkg::PERIOD_BITS-1:0];
        hms_pkg::CFG_STALL_LIMIT:     stall_limit     <= cfg_data[hms_pkg::LIMIT_BITS-1:0];
        hms_pkg::CFG_DIRECTION_LIMIT: direction_limit <= cfg_data[hms_pkg::LIMIT_BITS-1:0];
        hms_pkg::CFG_OPEN_LIMIT:      open_limit      <= cfg_data[hms_pkg::LIMIT_BITS-1:0];
        hms_pkg::CFG_SETTLE_TICKS:    settle_ticks    <= cfg_data[hms_pkg::SETTLE_BITS-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Open limit brought to the count width.
  logic [OPEN_EXT_BITS-1:0] open_ext;
  logic [COUNT_BITS-1:0]    open_bound;

  assign open_ext   = OPEN_EXT_BITS'(open_limit);
  assign open_bound = open_ext[COUNT_BITS-1:0];

  // --------------------------------------------------------------------------
  // Handshake: input register feeds the result register
  // --------------------------------------------------------------------------
  logic                  in_reg_valid;
  logic [COUNT_BITS-1:0] in_count;
  logic [1:0]            in_door;
  logic                  in_clear;
  logic                  advance;

  // Advance the held beat when the result register is free or draining.
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  // Hold the input while a beat waits that cannot advance.
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_count <= hall_count;
      in_door  <= door_state;
      in_clear <= flags_clear;
    end
  end

  // --------------------------------------------------------------------------
  // Supervision state
  // --------------------------------------------------------------------------
  logic [hms_pkg::PERIOD_BITS-1:0] sample_timer;
  logic [COUNT_BITS-1:0]           previous_count;
  logic [COUNT_BITS-1:0]           speed_reg;
  logic                            direction_reg;
  logic [hms_pkg::TIMER_BITS-1:0]  error_timer;
  logic [hms_pkg::SETTLE_BITS-1:0] settle_count;
  logic                            stall_sticky;
  logic                            fault_sticky;

  logic [hms_pkg::PERIOD_BITS-1:0] sample_timer_next;
  logic [COUNT_BITS-1:0]           previous_count_next;
  logic [COUNT_BITS-1:0]           speed_reg_next;
  logic                            direction_reg_next;
  logic [hms_pkg::TIMER_BITS-1:0]  error_timer_next;
  logic [hms_pkg::SETTLE_BITS-1:0] settle_count_next;
  logic                            stall_sticky_next;
  logic                            fault_sticky_next;

  logic [hms_pkg::PERIOD_BITS:0]   timer_inc;
  logic                            sample_now;
  logic                            count_rose;
  logic                            moving;
  logic                            opening;
  logic                            wrong_dir;
  logic                            checks_on;

  always_comb begin
    // Decode the door state; the unused code counts as idle.
    moving  = 1'b0;
    opening = 1'b0;
    case (in_door)
      hms_pkg::DOOR_OPENING: begin
        moving  = 1'b1;
        opening = 1'b1;
      end
      hms_pkg::DOOR_CLOSING: begin
        moving  = 1'b1;
      end
      default: begin
        moving  = 1'b0;
      end
    endcase
    // Opening expects a rising count, closing a falling one.
    wrong_dir = !opening;
    checks_on = settle_count >= settle_ticks;

    // Clear the sticky flags first when asked.
    stall_sticky_next = in_clear ? 1'b0 : stall_sticky;
    fault_sticky_next = in_clear ? 1'b0 : fault_sticky;

    // Speed sampling: the timer compares one past its value, so a period of
    // the maximum code still samples every 256 ticks.
    timer_inc           = {1'b0, sample_timer} + 1'b1;
    sample_now          = timer_inc > {1'b0, sample_period};
    count_rose          = in_count > previous_count;
    sample_timer_next   = timer_inc[hms_pkg::PERIOD_BITS-1:0];
    previous_count_next = previous_count;
    speed_reg_next      = speed_reg;
    direction_reg_next  = direction_reg;
    if (sample_now) begin
      sample_timer_next   = '0;
      direction_reg_next  = count_rose;
      speed_reg_next      = count_rose ? (in_count - previous_count)
                                       : (previous_count - in_count);
      previous_count_next = in_count;
    end

    // Motion check on the freshly sampled speed; limits see the old timer.
    error_timer_next = error_timer;
    if (checks_on) begin
      if (!moving) begin
        error_timer_next = '0;
      end else if (speed_reg_next == '0) begin
        if (error_timer > stall_limit) begin
          stall_sticky_next = 1'b1;
        end
        if (error_timer != hms_pkg::ERROR_TIMER_MAX) begin
          error_timer_next = error_timer + 1'b1;
        end
      end else if (direction_reg_next == wrong_dir) begin
        if (error_timer > direction_limit) begin
          fault_sticky_next = 1'b1;
        end
        if (error_timer != hms_pkg::ERROR_TIMER_MAX) begin
          error_timer_next = error_timer + 1'b1;
        end
      end else begin
        error_timer_next = '0;
      end
    end

    // Position check and settle counting.
    settle_count_next = settle_count;
    if (moving) begin
      if (opening && (in_count > open_bound)) begin
        fault_sticky_next = 1'b1;
      end
      if (settle_count < settle_ticks) begin
        settle_count_next = settle_count + 1'b1;
      end
    end else begin
      settle_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_timer   <= '0;
      previous_count <= '0;
      speed_reg      <= '0;
      direction_reg  <= 1'b0;
      error_timer    <= '0;
      settle_count   <= '0;
      stall_sticky   <= 1'b0;
      fault_sticky   <= 1'b0;
    end else if (advance) begin
      sample_timer   <= sample_timer_next;
      previous_count <= previous_count_next;
      speed_reg      <= speed_reg_next;
      direction_reg  <= direction_reg_next;
      error_timer    <= error_timer_next;
      settle_count   <= settle_count_next;
      stall_sticky   <= stall_sticky_next;
      fault_sticky   <= fault_sticky_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      speed         <= speed_reg_next;
      direction     <= direction_reg_next;
      stall_flag    <= stall_sticky_next;
      hall_fault    <= fault_sticky_next;
      checks_active <= settle_count_next >= settle_ticks;
    end
  end

endmodule
